@@ hw/rtl/gic_pkg.sv @@
// Shared types, constants and register indexes of the greedy interval cover unit.
`timescale 1ns / 1ps
package gic_pkg;

  localparam int DEF_MAX_INTERVALS = 64;
  localparam int RESULT_LIMIT      = 64;
  localparam int RES_W             = $clog2(RESULT_LIMIT + 1);

  localparam logic [0:0] REG_TARGET_START = 1'b0;
  localparam logic [0:0] REG_TARGET_END   = 1'b1;

  typedef struct packed {
    logic signed [31:0] span_start;
    logic signed [31:0] span_end;
    logic               final_span;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] chosen_start;
    logic signed [31:0] chosen_end;
    logic               no_cover;
    logic               last_result;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } span_t;

  // Classified word passed from the front to the back
  typedef struct packed {
    logic  store;
    logic  run;
    span_t span;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] target_start;
    logic signed [31:0] target_end;
  } target_t;

endpackage

@@ hw/rtl/gic_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module gic_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gic_front.sv @@
// Front end: accept input words, classify them as store, drop or run.
`timescale 1ns / 1ps
module gic_front #(
  parameter int MAX_INTERVALS = gic_pkg::DEF_MAX_INTERVALS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gic_pkg::in_word_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output gic_pkg::cmd_t    cmd
);
  import gic_pkg::*;

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  logic [CW-1:0] fill_r, fill_nxt;
  logic          accept;
  logic          room;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && cmd_ready;
  assign room     = fill_r < CW'(MAX_INTERVALS);

  // Classify: store while there is room, run on the final word
  always_comb begin
    cmd.store   = room;
    cmd.run     = in_data.final_span;
    cmd.span.lo = in_data.span_start;
    cmd.span.hi = in_data.span_end;
    cmd_valid   = in_valid && (room || in_data.final_span);
  end

  // Track how many intervals the current set holds
  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_data.final_span) begin
        fill_nxt = '0;
      end else if (room) begin
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ hw/rtl/gic_queue.sv @@
// Two-entry queue between the front end and the cover engine.
`timescale 1ns / 1ps
module gic_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gic_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gic_pkg::cmd_t pop_data
);
  import gic_pkg::*;

  cmd_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] used_r, used_nxt;
  logic       push, pop;

  assign push_ready = used_r != 2'd2;
  assign pop_valid  = used_r != 2'd0;
  assign pop_data   = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    used_nxt = used_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      used_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      used_r <= used_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/gic_back.sv @@
// Cover engine: store intervals, run the greedy rounds, drive the result word.
`timescale 1ns / 1ps
module gic_back #(
  parameter int MAX_INTERVALS = gic_pkg::DEF_MAX_INTERVALS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  gic_pkg::cmd_t      cmd,
  input  gic_pkg::target_t   target,
  output logic               out_valid,
  input  logic               out_ready,
  output gic_pkg::out_word_t out_data
);
  import gic_pkg::*;

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [2:0] {S_LOAD, S_START, S_SCAN, S_DECIDE} state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               emit_r, emit_nxt;
  logic               first_r, first_nxt;
  logic               found_r, found_nxt;
  logic [RES_W-1:0]   nres_r, nres_nxt;
  logic signed [31:0] reach_r, reach_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  span_t              best_r, best_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [63:0]        ram_rdata;
  span_t              rd_span;
  logic               slot_free;
  logic               cand, better, fail, done;

  assign rd_span   = span_t'(ram_rdata);
  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = state_r == S_LOAD;
  assign ram_we    = (state_r == S_LOAD) && cmd_valid && cmd.store;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gic_ram #(
    .WIDTH($bits(span_t)),
    .DEPTH(MAX_INTERVALS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(64'(cmd.span)),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Candidate of this round: start above the previous reach, at or below the reach
  assign cand   = (first_r || (rd_span.lo > prev_r)) && (rd_span.lo <= reach_r);
  assign better = !found_r || (rd_span.hi > best_r.hi) ||
                  ((rd_span.hi == best_r.hi) && (rd_span.lo >= best_r.lo));
  assign fail   = !found_r || (best_r.hi < reach_r) ||
                  (!first_r && (best_r.hi == reach_r)) ||
                  (nres_r >= RES_W'(RESULT_LIMIT));
  assign done   = best_r.hi >= target.target_end;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    emit_nxt      = emit_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    nres_nxt      = nres_r;
    reach_nxt     = reach_r;
    prev_nxt      = prev_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      // Take words from the queue, store intervals
      S_LOAD: begin
        if (cmd_valid) begin
          if (cmd.store) begin
            count_nxt = count_r + CW'(1);
          end
          if (cmd.run) begin
            emit_nxt  = 1'b0;
            state_nxt = S_START;
          end
        end
      end
      // Open a pass from the target start
      S_START: begin
        reach_nxt  = target.target_start;
        first_nxt  = 1'b1;
        found_nxt  = 1'b0;
        nres_nxt   = '0;
        rd_idx_nxt = '0;
        state_nxt  = S_SCAN;
      end
      // Sweep the store, keep the best candidate
      S_SCAN: begin
        if (rd_idx_r < count_r) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && cand && better) begin
          best_nxt  = rd_span;
          found_nxt = 1'b1;
        end
        if (!rd_vld_r && (rd_idx_r == count_r)) begin
          state_nxt = S_DECIDE;
        end
      end
      // Close the round: fail, next round, replay or emit
      S_DECIDE: begin
        if (fail) begin
          if (slot_free) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.chosen_start = '0;
            out_data_nxt.chosen_end   = '0;
            out_data_nxt.no_cover     = 1'b1;
            out_data_nxt.last_result  = 1'b1;
            count_nxt                 = '0;
            state_nxt                 = S_LOAD;
          end
        end else if (!emit_r) begin
          if (done) begin
            emit_nxt  = 1'b1;
            state_nxt = S_START;
          end else begin
            prev_nxt   = reach_r;
            reach_nxt  = best_r.hi;
            first_nxt  = 1'b0;
            found_nxt  = 1'b0;
            nres_nxt   = nres_r + RES_W'(1);
            rd_idx_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end else if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.chosen_start = best_r.lo;
          out_data_nxt.chosen_end   = best_r.hi;
          out_data_nxt.no_cover     = 1'b0;
          out_data_nxt.last_result  = done;
          if (done) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            prev_nxt   = reach_r;
            reach_nxt  = best_r.hi;
            first_nxt  = 1'b0;
            found_nxt  = 1'b0;
            nres_nxt   = nres_r + RES_W'(1);
            rd_idx_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      emit_r      <= 1'b0;
      first_r     <= 1'b1;
      found_r     <= 1'b0;
      nres_r      <= '0;
      reach_r     <= '0;
      prev_r      <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      emit_r      <= emit_nxt;
      first_r     <= first_nxt;
      found_r     <= found_nxt;
      nres_r      <= nres_nxt;
      reach_r     <= reach_nxt;
      prev_r      <= prev_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_INTERVALS)) else $error("interval count beyond store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= count_r))
    else $error("scan index past stored intervals");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_LOAD)) else $error("store written outside loading");

  a_reach_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !first_r) |-> (reach_r >= prev_r))
    else $error("reach fell between rounds");
`endif

endmodule

@@ hw/rtl/greedy_interval_cover_unit.sv @@
// Top level of the greedy interval cover unit: config registers, front, queue, engine.
// Loading: one word per cycle while the queue has room; no result until the final word.
// Run: two passes (check, then emit) of R rounds, each round a sweep of N stored intervals;
//   one result word per round on the emit pass.
// Throughput is set by the store's single read port swept once per round.
// Reset (rst_n low, synchronous): empty set, engine idle, targets zero, no result pending.
`timescale 1ns / 1ps
module greedy_interval_cover_unit #(
  parameter int MAX_INTERVALS = gic_pkg::DEF_MAX_INTERVALS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gic_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gic_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gic_pkg::*;

  target_t target_r, target_nxt;
  cmd_t    f_cmd, q_cmd;
  logic    f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // Write target registers
  always_comb begin
    target_nxt = target_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_START: target_nxt.target_start = cfg_data;
        REG_TARGET_END:   target_nxt.target_end   = cfg_data;
        default:          target_nxt = target_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else begin
      target_r <= target_nxt;
    end
  end

  gic_front #(.MAX_INTERVALS(MAX_INTERVALS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd      (f_cmd)
  );

  gic_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_cmd),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_cmd)
  );

  gic_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd      (q_cmd),
    .target   (target_r),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
